### rtl/core/plra_pkg.sv
// ----------------------------------------------------------------------------
// plra_pkg
// Shared constants, types and the rate scaling function of the per-weight
// learning rate adaptation core.
// ----------------------------------------------------------------------------
package plra_pkg;

    localparam int WEIGHT_COUNT = 1024;
    localparam int SLOT_W       = $clog2(WEIGHT_COUNT);
    localparam int INDEX_W      = 10;
    localparam int WEIGHT_W     = 32;
    localparam int RATE_W       = 32;
    localparam int FACTOR_W     = 16;
    localparam int PROD_W       = RATE_W + FACTOR_W;
    localparam int FRAC_SHIFT   = 14;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_RATE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INCREASE_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECREASE_FACTOR = 2'd2;

    localparam logic [RATE_W-1:0]   BASE_RATE_RST       = 32'd167772;
    localparam logic [FACTOR_W-1:0] INCREASE_FACTOR_RST = 16'd18022;
    localparam logic [FACTOR_W-1:0] DECREASE_FACTOR_RST = 16'd11469;

    typedef struct packed {
        logic [RATE_W-1:0]   first_rate;
        logic                first_clip;
        logic [FACTOR_W-1:0] increase_factor;
        logic [FACTOR_W-1:0] decrease_factor;
    } t_cfg;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic              clip;
    } t_scale;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [1:0]          sign;
        logic [RATE_W-1:0]   rate;
    } t_entry;

    // Round a Q8.24 x Q2.14 product to nearest, ties up, and saturate.
    function automatic t_scale f_scale(input logic [PROD_W-1:0] prod);
        logic [PROD_W:0]          sum;
        logic [PROD_W-FRAC_SHIFT:0] shifted;
        t_scale                   res;
        sum     = {1'b0, prod} + (PROD_W+1)'(1 << (FRAC_SHIFT - 1));
        shifted = sum[PROD_W:FRAC_SHIFT];
        res.clip = |shifted[PROD_W-FRAC_SHIFT:RATE_W];
        res.rate = res.clip ? {RATE_W{1'b1}} : shifted[RATE_W-1:0];
        return res;
    endfunction

endpackage

### rtl/core/plra_if.sv
// ----------------------------------------------------------------------------
// plra_if
// Valid/ready channels for weight words in and rate words out.
// ----------------------------------------------------------------------------
interface plra_in_if
    import plra_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [INDEX_W-1:0]         weight_index;
    logic signed [WEIGHT_W-1:0] weight_value;
    logic                       first_epoch;

    modport source (output valid, weight_index, weight_value, first_epoch, input ready);
    modport sink   (input valid, weight_index, weight_value, first_epoch, output ready);
endinterface

interface plra_out_if
    import plra_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index_out;
    logic [RATE_W-1:0]  new_rate;
    logic               rate_grew;
    logic               saturated;

    modport source (output valid, index_out, new_rate, rate_grew, saturated, input ready);
    modport sink   (input valid, index_out, new_rate, rate_grew, saturated, output ready);
endinterface

### rtl/core/plra_cfg.sv
// ----------------------------------------------------------------------------
// plra_cfg
// Configuration registers and the precomputed first-epoch starting rate.
// ----------------------------------------------------------------------------
module plra_cfg
    import plra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [RATE_W-1:0]   r_base_rate;
    logic [FACTOR_W-1:0] r_increase_factor;
    logic [FACTOR_W-1:0] r_decrease_factor;
    logic [PROD_W-1:0]   r_first_prod;
    t_scale              r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_rate       <= BASE_RATE_RST;
            r_increase_factor <= INCREASE_FACTOR_RST;
            r_decrease_factor <= DECREASE_FACTOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_RATE: begin
                    r_base_rate <= i_cfg_data[RATE_W-1:0];
                end
                CFG_INCREASE_FACTOR: begin
                    r_increase_factor <= i_cfg_data[FACTOR_W-1:0];
                end
                CFG_DECREASE_FACTOR: begin
                    r_decrease_factor <= i_cfg_data[FACTOR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The starting rate is recomputed after a write, through r_first_prod and then r_first.
    always_ff @(posedge i_clk) begin
        r_first_prod <= PROD_W'(r_base_rate) * PROD_W'(r_increase_factor);
        r_first      <= f_scale(r_first_prod);
    end

    assign o_cfg.first_rate      = r_first.rate;
    assign o_cfg.first_clip      = r_first.clip;
    assign o_cfg.increase_factor = r_increase_factor;
    assign o_cfg.decrease_factor = r_decrease_factor;

endmodule

### rtl/core/per_weight_learning_rate_adapt_core.sv
// ----------------------------------------------------------------------------
// per_weight_learning_rate_adapt_core
// Sign-based per-weight learning rate adaptation with a state memory.
//
// Channel   Direction  Word
// i_item    in         weight_index, weight_value, first_epoch
// o_result  out        index_out, new_rate, rate_grew, saturated
// i_cfg_*   in         plain register writes, no read-back
//
// One word per cycle for distinct slots; an accepted word passes through stages
// s1, s2 and s3 and the output register before it shows on o_result.
// A word whose slot matches one of the three words ahead of it waits until
// that word has written its slot back.
// Reset clears control only; the state memory needs no clearing pass.
// A stalled o_result freezes the whole pipeline.
// ----------------------------------------------------------------------------
module per_weight_learning_rate_adapt_core
    import plra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    plra_in_if.sink               i_item,
    plra_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg   w_cfg;
    t_entry r_mem [WEIGHT_COUNT];
    t_entry r_rd_data;

    logic                r_s1_valid;
    logic [INDEX_W-1:0]  r_s1_index;
    logic [WEIGHT_W-1:0] r_s1_weight;
    logic                r_s1_first;

    logic                r_s2_valid;
    logic [INDEX_W-1:0]  r_s2_index;
    logic [WEIGHT_W-1:0] r_s2_weight;
    logic [1:0]          r_s2_sign;
    logic                r_s2_grow;
    logic                r_s2_first;
    logic [RATE_W-1:0]   r_s2_rate;
    logic [FACTOR_W-1:0] r_s2_factor;

    logic                r_s3_valid;
    logic [INDEX_W-1:0]  r_s3_index;
    logic [WEIGHT_W-1:0] r_s3_weight;
    logic [1:0]          r_s3_sign;
    logic                r_s3_grow;
    logic                r_s3_clip;
    logic [PROD_W-1:0]   r_s3_prod;

    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_index;
    logic [RATE_W-1:0]   r_out_rate;
    logic                r_out_grew;
    logic                r_out_sat;

    logic                w_en;
    logic                w_hazard;
    logic                w_accept;
    logic [SLOT_W-1:0]   w_in_slot;
    logic [SLOT_W-1:0]   w_s1_slot;
    logic [SLOT_W-1:0]   w_s2_slot;
    logic [SLOT_W-1:0]   w_s3_slot;
    logic [WEIGHT_W:0]   w_diff;
    logic [1:0]          w_cur_sign;
    logic                w_grow;
    logic [RATE_W-1:0]   w_operand;
    t_scale              w_scaled;
    t_entry              w_wr_entry;

    plra_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_in_slot = SLOT_W'(i_item.weight_index % WEIGHT_COUNT);
    assign w_s1_slot = SLOT_W'(r_s1_index % WEIGHT_COUNT);
    assign w_s2_slot = SLOT_W'(r_s2_index % WEIGHT_COUNT);
    assign w_s3_slot = SLOT_W'(r_s3_index % WEIGHT_COUNT);

    assign w_en     = !r_out_valid || o_result.ready;
    assign w_hazard = (r_s1_valid && (w_s1_slot == w_in_slot))
                   || (r_s2_valid && (w_s2_slot == w_in_slot))
                   || (r_s3_valid && (w_s3_slot == w_in_slot));
    assign i_item.ready = w_en && !w_hazard;
    assign w_accept     = i_item.valid && i_item.ready;

    // Sign of the exact change since the last epoch.
    always_comb begin
        w_diff = {r_s1_weight[WEIGHT_W-1], r_s1_weight}
               - {r_rd_data.weight[WEIGHT_W-1], r_rd_data.weight};
        if (r_s1_first || (w_diff == '0)) begin
            w_cur_sign = SIGN_ZERO;
        end else if (w_diff[WEIGHT_W]) begin
            w_cur_sign = SIGN_NEG;
        end else begin
            w_cur_sign = SIGN_POS;
        end
        w_grow = (w_cur_sign != SIGN_ZERO) && (w_cur_sign == r_rd_data.sign);
    end

    assign w_operand = r_s2_first ? w_cfg.first_rate : r_s2_rate;
    assign w_scaled  = f_scale(r_s3_prod);

    assign w_wr_entry.weight = r_s3_weight;
    assign w_wr_entry.sign   = r_s3_sign;
    assign w_wr_entry.rate   = w_scaled.rate;

    always_ff @(posedge i_clk) begin
        if (w_en && r_s3_valid) begin
            r_mem[w_s3_slot] <= w_wr_entry;
        end
        if (w_accept) begin
            r_rd_data <= r_mem[w_in_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= w_accept;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_index  <= i_item.weight_index;
            r_s1_weight <= i_item.weight_value;
            r_s1_first  <= i_item.first_epoch;

            r_s2_index  <= r_s1_index;
            r_s2_weight <= r_s1_weight;
            r_s2_sign   <= w_cur_sign;
            r_s2_grow   <= w_grow;
            r_s2_first  <= r_s1_first;
            r_s2_rate   <= r_rd_data.rate;
            r_s2_factor <= w_grow ? w_cfg.increase_factor : w_cfg.decrease_factor;

            r_s3_index  <= r_s2_index;
            r_s3_weight <= r_s2_weight;
            r_s3_sign   <= r_s2_sign;
            r_s3_grow   <= r_s2_grow;
            r_s3_clip   <= r_s2_first && w_cfg.first_clip;
            r_s3_prod   <= PROD_W'(w_operand) * PROD_W'(r_s2_factor);

            r_out_index <= r_s3_index;
            r_out_rate  <= w_scaled.rate;
            r_out_grew  <= r_s3_grow;
            r_out_sat   <= r_s3_clip || w_scaled.clip;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.index_out = r_out_index;
    assign o_result.new_rate  = r_out_rate;
    assign o_result.rate_grew = r_out_grew;
    assign o_result.saturated = r_out_sat;

endmodule

### rtl/core/plra_checker.sv
// ----------------------------------------------------------------------------
// plra_checker
// Port-level checks of word flow through the adaptation core.
// ----------------------------------------------------------------------------
module plra_checker
    import plra_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [INDEX_W-1:0] i_out_index,
    input logic [RATE_W-1:0]  i_out_rate,
    input logic               i_out_grew,
    input logic               i_out_sat
);

    logic [2:0] r_count;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else begin
            r_count <= r_count + {2'b00, w_in_acc} - {2'b00, w_out_acc};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_index)
            && $stable(i_out_rate) && $stable(i_out_grew) && $stable(i_out_sat))
        else $error("result word changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_count != 3'd0)
        else $error("result word without an accepted input word");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("more words in flight than pipeline stages");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == 3'd4 && !i_out_ready |-> !i_in_ready)
        else $error("input accepted while pipeline full and output stalled");

endmodule

bind per_weight_learning_rate_adapt_core plra_checker u_plra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_index (o_result.index_out),
    .i_out_rate  (o_result.new_rate),
    .i_out_grew  (o_result.rate_grew),
    .i_out_sat   (o_result.saturated)
);

### test/tb_per_weight_learning_rate_adapt_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_weight_learning_rate_adapt_core
// Drives weight words into the rate adaptation core under several register
// settings and random idling on both channels. A tracker class keeps its own
// copy of the per-slot weight, change sign and rate, predicts every rate word
// and compares each one that comes out, field by field, in order.
// ----------------------------------------------------------------------------
module tb_per_weight_learning_rate_adapt_core;
    import plra_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int PHASE_WORDS   = 250;
    localparam int PHASES        = 6;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [RATE_W-1:0]  rate;
        logic               grew;
        logic               sat;
    } t_rate_word;

    class rate_tracker;
        logic [RATE_W-1:0]   base_rate;
        logic [FACTOR_W-1:0] up_factor;
        logic [FACTOR_W-1:0] down_factor;
        logic [WEIGHT_W-1:0] last_weight [WEIGHT_COUNT];
        logic [1:0]          last_sign [WEIGHT_COUNT];
        logic [RATE_W-1:0]   slot_rate [WEIGHT_COUNT];
        t_rate_word          pending_rates [$];
        int                  failures;
        int                  words_in;
        int                  first_count;
        int                  grew_count;
        int                  sat_count;

        function new();
            base_rate   = BASE_RATE_RST;
            up_factor   = INCREASE_FACTOR_RST;
            down_factor = DECREASE_FACTOR_RST;
            failures    = 0;
            words_in    = 0;
            first_count = 0;
            grew_count  = 0;
            sat_count   = 0;
        endfunction

        function void log_failure(string text);
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $display("%0t ns: %s", $time, text);
            end
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BASE_RATE: begin
                    base_rate = data;
                end
                CFG_INCREASE_FACTOR: begin
                    up_factor = data[FACTOR_W-1:0];
                end
                CFG_DECREASE_FACTOR: begin
                    down_factor = data[FACTOR_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function logic [RATE_W-1:0] scale_rate(logic [RATE_W-1:0] rate,
                                               logic [FACTOR_W-1:0] factor,
                                               inout bit clipped);
            longint unsigned prod;
            prod = rate;
            prod = prod * factor;
            prod = (prod + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
            if (prod > 64'h0000_0000_FFFF_FFFF) begin
                clipped = 1'b1;
                return {RATE_W{1'b1}};
            end
            return prod[RATE_W-1:0];
        endfunction

        function void add_weight_word(logic [INDEX_W-1:0] idx, logic [WEIGHT_W-1:0] value,
                                      logic first);
            int                slot;
            longint            delta;
            logic [RATE_W-1:0] rate;
            logic [1:0]        prior;
            logic [1:0]        now_sign;
            bit                clipped;
            bit                grow;
            t_rate_word        word;
            slot    = idx % WEIGHT_COUNT;
            clipped = 1'b0;
            if (first) begin
                rate     = scale_rate(base_rate, up_factor, clipped);
                prior    = SIGN_ZERO;
                now_sign = SIGN_ZERO;
                first_count++;
            end else begin
                delta    = longint'($signed(value)) - longint'($signed(last_weight[slot]));
                rate     = slot_rate[slot];
                prior    = last_sign[slot];
                now_sign = delta > 0 ? SIGN_POS : (delta < 0 ? SIGN_NEG : SIGN_ZERO);
            end
            grow = (now_sign != SIGN_ZERO) && (now_sign == prior);
            rate = scale_rate(rate, grow ? up_factor : down_factor, clipped);
            slot_rate[slot]   = rate;
            last_sign[slot]   = now_sign;
            last_weight[slot] = value;
            word.index = idx;
            word.rate  = rate;
            word.grew  = grow;
            word.sat   = clipped;
            pending_rates.push_back(word);
            words_in++;
        endfunction

        function void check_rate_word(logic [INDEX_W-1:0] idx, logic [RATE_W-1:0] rate,
                                      logic grew, logic sat);
            t_rate_word want;
            if (pending_rates.size() == 0) begin
                log_failure($sformatf("rate word with nothing pending: index %0d rate %h",
                                      idx, rate));
                return;
            end
            want = pending_rates.pop_front();
            grew_count += want.grew;
            sat_count  += want.sat;
            if (idx !== want.index || rate !== want.rate || grew !== want.grew
                    || sat !== want.sat) begin
                log_failure($sformatf(
                    "expected index %0d rate %h grew %0b sat %0b, got %0d %h %0b %0b",
                    want.index, want.rate, want.grew, want.sat, idx, rate, grew, sat));
            end
        endfunction

        function void close_out();
            if (pending_rates.size() != 0) begin
                log_failure($sformatf("%0d rate words never arrived", pending_rates.size()));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    plra_in_if  item_if ();
    plra_out_if result_if ();

    per_weight_learning_rate_adapt_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (result_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    rate_tracker tracker = new();

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;
    int hold_left   = 0;
    int quiet_cycles = 0;
    bit seeded [WEIGHT_COUNT];
    int seeded_slots [$];

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                tracker.check_rate_word(result_if.index_out, result_if.new_rate,
                                        result_if.rate_grew, result_if.saturated);
            end
            if (item_if.valid && item_if.ready) begin
                tracker.add_weight_word(item_if.weight_index, item_if.weight_value,
                                        item_if.first_epoch);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_if.valid && item_if.ready)
                || (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("No word moved for %0d cycles, %0d rate words pending",
                         STALL_LIMIT, tracker.pending_rates.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                result_if.ready = 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req        = 1'b0;
                hold_left       = HOLD_CYCLES - 1;
                result_if.ready = 1'b0;
            end else begin
                result_if.ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [INDEX_W-1:0] idx, input logic [WEIGHT_W-1:0] value,
                             input logic first);
        bit taken;
        while ($urandom_range(99) < tx_idle_pct) begin
            item_if.valid = 1'b0;
            @(negedge i_clk);
        end
        item_if.valid        = 1'b1;
        item_if.weight_index = idx;
        item_if.weight_value = value;
        item_if.first_epoch  = first;
        if (first && !seeded[idx]) begin
            seeded[idx] = 1'b1;
            seeded_slots.push_back(idx);
        end
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = item_if.ready;
            @(negedge i_clk);
        end
    endtask

    task automatic drain();
        item_if.valid = 1'b0;
        while (tracker.pending_rates.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        tracker.write_register(idx, data);
    endtask

    task automatic apply_setting(input logic [RATE_W-1:0] base,
                                 input logic [FACTOR_W-1:0] up,
                                 input logic [FACTOR_W-1:0] down);
        logic [15:0] junk_a;
        logic [15:0] junk_b;
        junk_a = 16'($urandom);
        junk_b = 16'($urandom);
        write_register(CFG_BASE_RATE, base);
        write_register(CFG_INCREASE_FACTOR, {junk_a, up});
        write_register(CFG_DECREASE_FACTOR, {junk_b, down});
    endtask

    // Most traffic is epoch sequences over a few slots: a first-epoch word per
    // slot, then several epochs of trending weights. The rest is stray words.
    task automatic random_traffic(input int count);
        int                  sent;
        int                  pick;
        int                  pool;
        int                  epochs;
        int                  roll;
        logic [INDEX_W-1:0]  slots [6];
        logic [WEIGHT_W-1:0] level [6];
        bit                  fall [6];
        logic [WEIGHT_W-1:0] step;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                pool   = $urandom_range(1, 6);
                epochs = $urandom_range(2, 8);
                for (int s = 0; s < pool; s++) begin
                    slots[s] = INDEX_W'($urandom);
                    level[s] = pick_weight();
                    fall[s]  = 1'($urandom_range(1));
                    send_word(slots[s], level[s], 1'b1);
                end
                sent += pool;
                for (int e = 1; e < epochs; e++) begin
                    for (int s = 0; s < pool; s++) begin
                        if ($urandom_range(99) < 25) begin
                            fall[s] = !fall[s];
                        end
                        roll = $urandom_range(99);
                        if (roll < 10) begin
                            step = '0;
                        end else if (roll < 70) begin
                            step = $urandom_range(1, 1000);
                        end else if (roll < 90) begin
                            step = $urandom_range(1, 1 << 20);
                        end else begin
                            step = $urandom;
                        end
                        level[s] = fall[s] ? level[s] - step : level[s] + step;
                        send_word(slots[s], level[s], 1'b0);
                        sent++;
                    end
                end
            end else if (pick < 85 && seeded_slots.size() > 0) begin
                send_word(INDEX_W'(seeded_slots[$urandom_range(seeded_slots.size() - 1)]),
                          pick_weight(), 1'b0);
                sent++;
            end else begin
                send_word(INDEX_W'($urandom), pick_weight(), 1'b1);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_BASE_RATE;
        i_cfg_data           = '0;
        item_if.valid        = 1'b0;
        item_if.weight_index = '0;
        item_if.weight_value = '0;
        item_if.first_epoch  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            case (p / 2)
                0: begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 46;
                end
                1: begin
                    tx_idle_pct = 46;
                    rx_idle_pct = 20;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (p)
                0: begin
                    send_word(10'd0, 32'h0000_0000, 1'b1);
                    send_word(10'd1023, 32'h7FFF_FFFF, 1'b1);
                    send_word(10'd512, 32'h8000_0000, 1'b1);
                    send_word(10'd0, 32'd5, 1'b0);
                    send_word(10'd0, 32'd10, 1'b0);
                    send_word(10'd0, 32'd10, 1'b0);
                    send_word(10'd0, 32'd3, 1'b0);
                    send_word(10'd0, 32'd1, 1'b0);
                    send_word(10'd0, 32'd4, 1'b0);
                    send_word(10'd1023, 32'h8000_0000, 1'b0);
                    send_word(10'd512, 32'h7FFF_FFFF, 1'b0);
                    send_word(10'd1023, 32'h8000_0000, 1'b0);
                    send_word(10'd512, 32'hFFFF_FFFF, 1'b0);
                    send_word(10'd0, 32'hFFFF_FFFF, 1'b1);
                    send_word(10'd0, 32'h0000_0001, 1'b0);
                end
                1: begin
                    apply_setting(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
                    send_word(10'd7, 32'd100, 1'b1);
                    send_word(10'd7, 32'd200, 1'b0);
                    send_word(10'd7, 32'd300, 1'b0);
                end
                2: begin
                    apply_setting(32'h0000_0000, 16'h0000, 16'h0000);
                    write_register(CFG_UNUSED, $urandom);
                    send_word(10'd7, 32'd400, 1'b1);
                    send_word(10'd7, 32'd500, 1'b0);
                end
                3: begin
                    apply_setting($urandom, FACTOR_W'($urandom_range(16384, 32767)),
                                  FACTOR_W'($urandom_range(0, 16383)));
                end
                4: begin
                    apply_setting($urandom_range(1, 1 << 24),
                                  FACTOR_W'($urandom_range(16384, 20000)),
                                  FACTOR_W'($urandom_range(8000, 16383)));
                    hold_req = 1'b1;
                end
                default: begin
                    apply_setting($urandom, FACTOR_W'($urandom), FACTOR_W'($urandom));
                end
            endcase
            random_traffic(PHASE_WORDS);
            drain();
        end

        tracker.close_out();
        $display("Ran %0d weight words through %0d register settings: %0d first-epoch starts,",
                 tracker.words_in, PHASES, tracker.first_count);
        $display("%0d rate increases, %0d saturated words, idling on both sides,",
                 tracker.grew_count, tracker.sat_count);
        $display("one %0d-cycle hold on the result side.", HOLD_CYCLES);
        if (tracker.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d failures", tracker.failures);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/plra_pkg.sv
rtl/core/plra_if.sv
rtl/core/plra_cfg.sv
rtl/core/per_weight_learning_rate_adapt_core.sv
rtl/core/plra_checker.sv
test/tb_per_weight_learning_rate_adapt_core.sv
